>>> rtl/hexl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexl_pkg
// Shared types, codes and helpers of the Intel HEX memory loader.
// ----------------------------------------------------------------------------
package hexl_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int MAX_LINE_DEF  = 521;

  localparam int IN_W   = 40;
  localparam int OUT_W  = 16;
  localparam int LINE_W = 10;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_EOF  = 8'h01;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_BEGIN = 3'd2,
    OP_CHAR  = 3'd3,
    OP_EOI   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    LS_IDLE     = 3'd0,
    LS_LOADING  = 3'd1,
    LS_SUCCESS  = 3'd2,
    LS_NO_COLON = 3'd3,
    LS_CHECKSUM = 3'd4,
    LS_TOO_LONG = 3'd5,
    LS_NO_END   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_COMMIT
  } state_t;

  // hex digit value; anything that is not a hex digit counts as zero
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] lc;
    logic [3:0] r;
    lc = c | 8'h20;
    r  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      r = 4'(lc - 8'h57);
    end
    return r;
  endfunction

endpackage

>>> rtl/hexl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hexl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/intel_hex_memory_loader.sv
`timescale 1ns / 1ps
// Write, text character and end of input answer from the output register; a read
//   passes the registered RAM read first; a committed data line and begin load
//   answer at the end of their sweep. No new transaction is taken until the output
//   drains; begin load and a committed line hold the input for their sweep.
// Reset: synchronous; the same fill sweep runs after reset, during which s_tready
//   stays low. Loader status resets to idle.
// ----------------------------------------------------------------------------
// intel_hex_memory_loader
// Byte memory with a character-at-a-time Intel HEX record loader.
// ----------------------------------------------------------------------------
module intel_hex_memory_loader
  import hexl_pkg::*;
#(
  parameter int MEM_BYTES      = MEM_BYTES_DEF,  // power of two
  parameter int MAX_LINE_CHARS = MAX_LINE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode[2:0], mem_address[18:3], write_value[26:19], text_char[34:27]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // read_value[7:0], load_status[10:8]
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(MEM_BYTES);

  // ---- input decode
  logic [2:0]  in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_wval;
  logic [7:0]  in_char;
  logic        acc;

  assign in_op   = s_tdata[2:0];
  assign in_addr = s_tdata[18:3];
  assign in_wval = s_tdata[26:19];
  assign in_char = s_tdata[34:27];
  assign acc     = s_tvalid && s_tready;

  // ---- state
  state_t      state, state_next;
  logic [AW-1:0] fill_cnt;
  logic        fill_report;      // begin load: emit a result when fill ends
  status_t     status;

  // current record
  logic [LINE_W-1:0] line_pos;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_kind;
  logic [7:0]  sum_acc;
  logic [3:0]  hi_nib;
  logic        colon_seen;

  // commit sweep
  logic [8:0]  cm_cnt;
  logic [7:0]  cm_len;
  logic [15:0] cm_base;
  logic        cm_eoi;           // end of input pending behind the commit
  logic        wr_valid;
  logic [15:0] wr_addr;
  logic        cm_done;

  // ---- memories
  logic          main_we;
  logic [AW-1:0] main_waddr;
  logic [7:0]    main_wdata;
  logic [7:0]    main_q;
  logic          stg_we;
  logic [7:0]    stg_waddr;
  logic [7:0]    stg_q;

  hexl_ram #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_main (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (in_addr[AW-1:0]),
    .rdata (main_q)
  );

  hexl_ram #(.DEPTH(256), .WIDTH(8)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata ({hi_nib, digit_val(in_char)}),
    .raddr (cm_cnt[7:0]),
    .rdata (stg_q)
  );

  // ---- line-end evaluation
  logic [LINE_W-1:0] need;
  status_t fin_status;
  logic    fin_commit;

  assign need = LINE_W'(11) + {1'b0, rec_len, 1'b0};

  always_comb begin
    fin_status = status;
    fin_commit = 1'b0;
    if (!colon_seen) begin
      fin_status = LS_NO_COLON;
    end else if (line_pos < need || sum_acc != 8'd0) begin
      fin_status = LS_CHECKSUM;
    end else if (rec_kind == KIND_DATA) begin
      fin_commit = (rec_len != 8'd0);
    end else if (rec_kind == KIND_EOF) begin
      fin_status = LS_SUCCESS;
    end
  end

  // ---- character take
  logic [LINE_W-1:0] tc_p;
  logic [8:0]        tc_b;
  logic [7:0]        tc_v;
  logic              tc_in_rec;
  logic [8:0]        tc_di;

  assign tc_p      = line_pos - LINE_W'(1);
  assign tc_b      = tc_p[LINE_W-1:1];
  assign tc_v      = {hi_nib, digit_val(in_char)};
  assign tc_in_rec = {1'b0, tc_b} < ({2'b00, rec_len} + LINE_W'(5));
  assign tc_di     = tc_b - 9'd4;

  logic is_load, is_char_take, is_nl, is_toolong, is_eoi;
  assign is_load      = (status == LS_LOADING);
  assign is_nl        = in_op == OP_CHAR && is_load && in_char == CH_NL;
  assign is_toolong   = in_op == OP_CHAR && is_load && in_char != CH_NL &&
                        line_pos >= LINE_W'(MAX_LINE_CHARS);
  assign is_char_take = in_op == OP_CHAR && is_load && in_char != CH_NL &&
                        line_pos < LINE_W'(MAX_LINE_CHARS);
  assign is_eoi       = in_op == OP_EOI && is_load;

  logic go_commit;
  assign go_commit = fin_commit && (is_nl || (is_eoi && line_pos != '0));

  assign cm_done = (cm_cnt == {1'b0, cm_len}) && !wr_valid;

  // status reported by a transaction that completes at its accept
  status_t acc_status;
  always_comb begin
    acc_status = status;
    if (is_nl) begin
      acc_status = fin_status;
    end else if (is_toolong) begin
      acc_status = LS_TOO_LONG;
    end else if (is_eoi) begin
      acc_status = (line_pos != '0 && fin_status != LS_LOADING) ? fin_status : LS_NO_END;
    end
  end

  // ---- next state
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (fill_cnt == AW'(MEM_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (in_op == OP_READ) begin
            state_next = S_READ;
          end else if (in_op == OP_BEGIN) begin
            state_next = S_FILL;
          end else if (go_commit) begin
            state_next = S_COMMIT;
          end
        end
      end
      S_READ:   state_next = S_IDLE;
      S_COMMIT: begin
        if (cm_done) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    s_tready   = 1'b0;
    main_we    = 1'b0;
    main_waddr = in_addr[AW-1:0];
    main_wdata = in_wval;
    stg_we     = 1'b0;
    stg_waddr  = tc_di[7:0];
    case (state)
      S_FILL: begin
        main_we    = 1'b1;
        main_waddr = fill_cnt;
        main_wdata = FILL_BYTE;
      end
      S_IDLE: begin
        s_tready = !m_tvalid;
        main_we  = acc && in_op == OP_WRITE;
        stg_we   = acc && is_char_take && line_pos != '0 && tc_p[0] && tc_in_rec &&
                   tc_b >= 9'd4 && tc_di < {1'b0, rec_len};
      end
      S_COMMIT: begin
        main_we    = wr_valid;
        main_waddr = wr_addr[AW-1:0];
        main_wdata = stg_q;
      end
      default: begin
      end
    endcase
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill_cnt    <= '0;
      fill_report <= 1'b0;
      status      <= LS_IDLE;
      m_tvalid    <= 1'b0;
      wr_valid    <= 1'b0;
      cm_cnt      <= '0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_cnt <= fill_cnt + AW'(1);
          if (fill_cnt == AW'(MEM_BYTES - 1)) begin
            fill_report <= 1'b0;
            m_tvalid    <= fill_report;
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (in_op == OP_BEGIN) begin
              fill_cnt    <= '0;
              fill_report <= 1'b1;
              status      <= LS_LOADING;
            end else if (go_commit) begin
              cm_cnt   <= '0;
              wr_valid <= 1'b0;
            end else if (in_op != OP_READ) begin
              m_tvalid <= 1'b1;
              if (is_nl) begin
                status <= fin_status;
              end else if (is_toolong) begin
                status <= LS_TOO_LONG;
              end else if (is_eoi) begin
                // a partial line that ends in an error or an end record reports that; else flag a missing end record
                if (line_pos != '0 && fin_status != LS_LOADING) begin
                  status <= fin_status;
                end else begin
                  status <= LS_NO_END;
                end
              end
            end
          end
        end
        S_READ: m_tvalid <= 1'b1;
        S_COMMIT: begin
          wr_valid <= cm_cnt != {1'b0, cm_len};
          if (cm_cnt != {1'b0, cm_len}) begin
            cm_cnt <= cm_cnt + 9'd1;
          end
          if (cm_done) begin
            m_tvalid <= 1'b1;
            if (cm_eoi) begin
              status <= LS_NO_END;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      wr_addr <= cm_base + {7'd0, cm_cnt};
    end
    if (state == S_READ) begin
      m_tdata <= {5'd0, status, main_q};
    end else if (state == S_COMMIT && cm_done) begin
      m_tdata <= {5'd0, (cm_eoi ? LS_NO_END : status), 8'd0};
    end else if (state == S_FILL) begin
      m_tdata <= {5'd0, status, 8'd0};
    end else if (acc && !go_commit && in_op != OP_READ) begin
      m_tdata <= {5'd0, acc_status, 8'd0};
    end
  end

  // ---- record parser
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos   <= '0;
      rec_len    <= '0;
      rec_addr   <= '0;
      rec_kind   <= '0;
      sum_acc    <= '0;
      hi_nib     <= '0;
      colon_seen <= 1'b0;
    end else if (acc) begin
      if (in_op == OP_BEGIN || is_nl || is_toolong || is_eoi) begin
        if (go_commit) begin
          cm_len  <= rec_len;
          cm_base <= rec_addr;
          cm_eoi  <= is_eoi;
        end
        line_pos   <= '0;
        rec_len    <= '0;
        rec_addr   <= '0;
        rec_kind   <= '0;
        sum_acc    <= '0;
        hi_nib     <= '0;
        colon_seen <= 1'b0;
      end else if (is_char_take) begin
        line_pos <= line_pos + LINE_W'(1);
        if (line_pos == '0) begin
          colon_seen <= (in_char == CH_COLON);
        end else if (!tc_p[0]) begin
          hi_nib <= digit_val(in_char);
        end else if (tc_in_rec) begin
          sum_acc <= sum_acc + tc_v;
          case (tc_b)
            9'd0:    rec_len        <= tc_v;
            9'd1:    rec_addr[15:8] <= tc_v;
            9'd2:    rec_addr[7:0]  <= tc_v;
            9'd3:    rec_kind       <= tc_v;
            default: begin
            end
          endcase
        end
      end
    end
  end

  // ---- assertions
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid && state == S_IDLE))
    else $error("ready while output busy");

  a_cm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (cm_cnt <= {1'b0, cm_len}))
    else $error("commit count overrun");

  a_read_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> m_tvalid)
    else $error("read produced no result");

  a_fill_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (main_we && !stg_we))
    else $error("fill sweep stalled");

endmodule
